// File: design/sbd_pkg.sv
// ----------------------------------------------------------------------------
// sbd_pkg: shared types and constants of the sortable byte deque
// Holds the ring depth, the derived widths, the action and status codes,
// and the item and result structures passed between the modules.
// ----------------------------------------------------------------------------
package sbd_pkg;

  // Ring depth. It must be a power of two, because ring positions wrap by
  // dropping the carry out of the index adders.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    ACT_PUSH_HEAD = 3'd0,
    ACT_PUSH_TAIL = 3'd1,
    ACT_POP_HEAD  = 3'd2,
    ACT_POP_TAIL  = 3'd3,
    ACT_SORT      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    action_e            action;
    logic signed [7:0]  value;
    logic               descending;
  } item_t;

  typedef struct packed {
    logic signed [7:0]  value;
    status_e            status;
  } result_t;

endpackage

// File: design/sortable_byte_deque.sv
// ----------------------------------------------------------------------------
// sortable_byte_deque: double-ended queue of signed bytes with bubble sort
// A push or a refused action goes from the idle state to ST_HOLD and on to the
// output register, a pop passes ST_POP on the way; the sequencer takes one
// transaction at a time. A sort walks adjacent pairs one at a time through
// the single compare unit, and a swap takes two writes through the single
// write port of the ring memory; passes repeat until a pass makes no swap.
// Reset empties the queue; the ring contents are not cleared.
// ----------------------------------------------------------------------------
module sortable_byte_deque (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [7:0] value_in, [8] descending, rest zero
  input  logic [2:0]  s_axis_tuser,  // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] value_out
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  import sbd_pkg::*;

  item_t   item;
  result_t res;
  logic    res_valid;
  logic    res_ready;
  logic    out_valid_q;
  result_t out_q;

  assign item.action     = action_e'(s_axis_tuser);
  assign item.value      = s_axis_tdata[7:0];
  assign item.descending = s_axis_tdata[8];

  sbd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: the sequencer may start the next transaction while a
  // result is still waiting here.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.value;
  assign m_axis_tuser  = out_q.status;

endmodule

// File: design/sbd_cmp.sv
// ----------------------------------------------------------------------------
// sbd_cmp: order compare unit of the bubble sort
// Decides whether an adjacent pair of signed bytes is strictly out of order
// for the requested direction. Equal values are never swapped.
// ----------------------------------------------------------------------------
module sbd_cmp (
  input  logic signed [7:0] a_i,
  input  logic signed [7:0] b_i,
  input  logic              descending_i,
  output logic              swap_o
);

  always_comb begin
    if (descending_i) begin
      swap_o = (a_i < b_i);
    end else begin
      swap_o = (a_i > b_i);
    end
  end

endmodule

// File: design/sbd_ctrl.sv
// ----------------------------------------------------------------------------
// sbd_ctrl: sequencer and ring storage of the sortable byte deque
// Executes one action at a time on a ring buffer memory with one write port
// and two registered read ports. The sort walks adjacent pairs through the
// shared compare unit and swaps a pair with two single-port writes.
// ----------------------------------------------------------------------------
module sbd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sbd_pkg::item_t   in_item_i,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sbd_pkg::result_t res_o
);

  import sbd_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_POP  = 6'b000010,
    ST_RD   = 6'b000100,
    ST_CMP  = 6'b001000,
    ST_WR2  = 6'b010000,
    ST_HOLD = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   head_q, head_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic               swapped_q, swapped_d;
  logic               desc_q, desc_d;
  result_t            res_q, res_d;

  logic [7:0]         mem [DEPTH];
  logic signed [7:0]  rd_a_q, rd_b_q;
  logic               rd_en;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic [7:0]         wd;
  logic [IDX_W-1:0]   off_a;
  logic [IDX_W-1:0]   idx_a, idx_b;
  logic               full, empty;
  logic               swap;
  logic               in_fire;

  assign full    = (cnt_q == CNT_W'(DEPTH));
  assign empty   = (cnt_q == '0);
  assign in_fire = in_valid_i && in_ready_o;

  assign idx_a = head_q + off_a;
  assign idx_b = head_q + k_q[IDX_W-1:0] + IDX_W'(1);

  sbd_cmp u_cmp (
    .a_i          (rd_a_q),
    .b_i          (rd_b_q),
    .descending_i (desc_q),
    .swap_o       (swap)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_a_q <= mem[idx_a];
      rd_b_q <= mem[idx_b];
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    k_d       = k_q;
    swapped_d = swapped_q;
    desc_d    = desc_q;
    res_d     = res_q;
    rd_en     = 1'b0;
    we        = 1'b0;
    wa        = idx_a;
    wd        = rd_b_q;
    off_a     = k_q[IDX_W-1:0];
    in_ready_o  = (state_q == ST_IDLE);
    res_valid_o = (state_q == ST_HOLD);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d.value  = '0;
          res_d.status = STAT_OK;
          state_d      = ST_HOLD;
          case (in_item_i.action)
            ACT_PUSH_HEAD: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                we     = 1'b1;
                wa     = head_q - IDX_W'(1);
                wd     = in_item_i.value;
                head_d = head_q - IDX_W'(1);
                cnt_d  = cnt_q + CNT_W'(1);
              end
            end
            ACT_PUSH_TAIL: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                we    = 1'b1;
                wa    = head_q + cnt_q[IDX_W-1:0];
                wd    = in_item_i.value;
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            ACT_POP_HEAD: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                off_a   = '0;
                rd_en   = 1'b1;
                head_d  = head_q + IDX_W'(1);
                cnt_d   = cnt_q - CNT_W'(1);
                state_d = ST_POP;
              end
            end
            ACT_POP_TAIL: begin
              if (empty) begin
                res_d.status = STAT_EMPTY;
              end else begin
                off_a   = cnt_q[IDX_W-1:0] - IDX_W'(1);
                rd_en   = 1'b1;
                cnt_d   = cnt_q - CNT_W'(1);
                state_d = ST_POP;
              end
            end
            ACT_SORT: begin
              desc_d = in_item_i.descending;
              if (cnt_q >= CNT_W'(2)) begin
                k_d       = '0;
                swapped_d = 1'b0;
                state_d   = ST_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        res_d.value = rd_a_q;
        state_d     = ST_HOLD;
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_CMP;
      end
      ST_CMP, ST_WR2: begin
        if (state_q == ST_CMP && swap) begin
          // First half of the swap: the lower slot takes the upper byte.
          we        = 1'b1;
          wa        = idx_a;
          wd        = rd_b_q;
          swapped_d = 1'b1;
          state_d   = ST_WR2;
        end else begin
          if (state_q == ST_WR2) begin
            we = 1'b1;
            wa = idx_b;
            wd = rd_a_q;
          end
          // Advance to the next pair, start a new pass, or finish.
          if ((k_q + CNT_W'(2)) < cnt_q) begin
            k_d     = k_q + CNT_W'(1);
            state_d = ST_RD;
          end else if (swapped_q) begin
            k_d       = '0;
            swapped_d = 1'b0;
            state_d   = ST_RD;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      head_q    <= '0;
      cnt_q     <= '0;
      k_q       <= '0;
      swapped_q <= 1'b0;
      desc_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      cnt_q     <= cnt_d;
      k_q       <= k_d;
      swapped_q <= swapped_d;
      desc_q    <= desc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // A sort pass only visits pairs that lie inside the live region.
  a_pair_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> ((k_q + CNT_W'(1)) < cnt_q))
    else $error("sort pair index beyond fill count");

  // The sort leaves the head position and the fill count untouched.
  a_sort_keeps_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> ($stable(cnt_q) && $stable(head_q)))
    else $error("ring pointers changed during sort");

  // The second write of a swap always follows a compare that asked for it.
  a_wr2_after_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR2) |-> ($past(state_q) == ST_CMP && swapped_q))
    else $error("swap completion without a swap decision");

  // A refused push leaves the queue full and returns status FULL.
  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && full && (in_item_i.action == ACT_PUSH_HEAD ||
     in_item_i.action == ACT_PUSH_TAIL)) |=> (full && res_q.status == STAT_FULL))
    else $error("push into a full queue was not refused");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sortable byte deque
// Drives push, pop, sort and unused actions on the input stream, with random
// stalls on both streams. A scoreboard keeps its own copy of the ring and
// predicts every reply, which is checked in order against the output stream.
// ----------------------------------------------------------------------------
module testbench;
  import sbd_pkg::*;

  localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
  localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
  localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
  localparam int unsigned ITEM_TARGET = 1400;

  class deque_scoreboard;
    logic signed [7:0] slots [DEPTH];
    int unsigned front;
    int unsigned count;
    result_t replies_due[$];
    int unsigned mismatches;

    function new();
      front = 0;
      count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void bubble_sort(input bit desc);
      bit swapped;
      int unsigned k;
      int unsigned pa;
      int unsigned pb;
      logic signed [7:0] a;
      logic signed [7:0] b;
      swapped = 1'b1;
      while (swapped && count > 1) begin
        swapped = 1'b0;
        for (k = 0; k + 1 < count; k++) begin
          pa = (front + k) % DEPTH;
          pb = (front + k + 1) % DEPTH;
          a = slots[pa];
          b = slots[pb];
          if (desc ? (a < b) : (a > b)) begin
            slots[pa] = b;
            slots[pb] = a;
            swapped = 1'b1;
          end
        end
      end
    endfunction

    // Applies one accepted transaction and queues the reply it must produce.
    function void note_action(input logic [2:0] code, input logic [7:0] value,
                              input logic desc);
      result_t reply;
      reply.value  = '0;
      reply.status = STAT_OK;
      case (action_e'(code))
        ACT_PUSH_HEAD: begin
          if (count >= DEPTH) begin
            reply.status = STAT_FULL;
          end else begin
            front = (front + DEPTH - 1) % DEPTH;
            slots[front] = value;
            count++;
          end
        end
        ACT_PUSH_TAIL: begin
          if (count >= DEPTH) begin
            reply.status = STAT_FULL;
          end else begin
            slots[(front + count) % DEPTH] = value;
            count++;
          end
        end
        ACT_POP_HEAD: begin
          if (count == 0) begin
            reply.status = STAT_EMPTY;
          end else begin
            reply.value = slots[front];
            front = (front + 1) % DEPTH;
            count--;
          end
        end
        ACT_POP_TAIL: begin
          if (count == 0) begin
            reply.status = STAT_EMPTY;
          end else begin
            reply.value = slots[(front + count - 1) % DEPTH];
            count--;
          end
        end
        ACT_SORT: bubble_sort(desc);
        default: ;
      endcase
      replies_due.push_back(reply);
    endfunction

    task check_reply(input logic [7:0] value, input logic [1:0] status);
      result_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply value %0d status %0d with nothing outstanding",
                         $signed(value), status));
      end else begin
        want = replies_due.pop_front();
        if (value !== want.value)
          report($sformatf("value_out %0d, predicted %0d", $signed(value), want.value));
        if (status !== want.status)
          report($sformatf("status %0d, predicted %0d", status, want.status));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [7:0] value_in, [8] descending, rest zero
  logic [2:0]  s_axis_tuser = '0;  // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;       // [7:0] value_out
  logic [1:0]  m_axis_tuser;       // [1:0] status

  deque_scoreboard board = new();
  bit quiet = 1'b0;
  int unsigned items_sent = 0;

  sortable_byte_deque uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Biased toward the extremes and toward a narrow band that forces duplicates.
  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 8'h80;
      1: return 8'h7f;
      2: return $urandom_range(0, 1) ? 8'hff : 8'h00;
      3, 4: return 8'($urandom_range(0, 6) - 3);
      default: return 8'($urandom);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        board.note_action(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]);
      if (m_axis_tvalid && m_axis_tready)
        board.check_reply(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  // Returns at the edge where the transaction is taken; valid stays high so
  // the next call can follow without a bubble.
  task automatic send(input logic [2:0] code, input logic [7:0] value, input logic desc);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, desc, value};
    s_axis_tuser  <= code;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (code <= ACT_SORT) items_sent++;
  endtask

  task automatic push_random();
    send($urandom_range(0, 1) ? ACT_PUSH_HEAD : ACT_PUSH_TAIL, pick_byte(),
         1'($urandom));
  endtask

  task automatic pop_random();
    send($urandom_range(0, 1) ? ACT_POP_HEAD : ACT_POP_TAIL, pick_byte(), 1'($urandom));
  endtask

  task automatic wait_for_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_mixed(input int unsigned n);
    int unsigned r;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 44) push_random();
      else if (r < 84) pop_random();
      else if (r < 94) send(ACT_SORT, pick_byte(), 1'($urandom));
      else send(3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST)), pick_byte(),
                1'($urandom));
    end
  endtask

  initial begin
    bit first;
    first = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty queue, single entry, extremes, both sort orders, spare codes.
    send(ACT_POP_HEAD,  8'h00, 1'b0);
    send(ACT_POP_TAIL,  8'hff, 1'b1);
    send(ACT_SORT,      8'h00, 1'b0);
    send(ACT_PUSH_TAIL, 8'h7f, 1'b0);
    send(ACT_SORT,      8'h00, 1'b1);
    send(ACT_POP_HEAD,  8'h00, 1'b0);
    send(ACT_POP_TAIL,  8'h00, 1'b0);
    send(ACT_POP_HEAD,  8'h00, 1'b0);
    send(ACT_PUSH_HEAD, 8'h80, 1'b0);
    send(ACT_PUSH_TAIL, 8'h55, 1'b1);
    send(ACT_PUSH_HEAD, 8'haa, 1'b0);
    send(ACT_PUSH_TAIL, 8'hff, 1'b0);
    send(ACT_PUSH_HEAD, 8'h01, 1'b1);
    send(ACT_PUSH_TAIL, 8'h7f, 1'b0);
    send(ACT_SORT,      8'h00, 1'b0);
    send(ACT_SORT,      8'hff, 1'b1);
    send(ACT_POP_HEAD,  8'h00, 1'b0);
    send(ACT_POP_TAIL,  8'h00, 1'b1);
    send(ACT_SPARE_FIRST, 8'h5a, 1'b1);
    send(ACT_SPARE_MID, 8'ha5, 1'b0);
    send(ACT_SPARE_LAST, 8'hff, 1'b1);
    send(ACT_SORT,      8'h00, 1'b0);
    wait_for_replies();

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      case (first ? 0 : $urandom_range(0, 3))
        0: begin
          // Fill past full, sorting on the way now and then.
          repeat (DEPTH + $urandom_range(1, 2)) begin
            push_random();
            if ($urandom_range(0, 15) == 0) send(ACT_SORT, pick_byte(), 1'($urandom));
          end
          send(ACT_SORT, pick_byte(), 1'($urandom));
        end
        1: repeat (DEPTH + $urandom_range(1, 2)) pop_random();
        2: begin
          repeat ($urandom_range(0, 6)) push_random();
          send(ACT_SORT, pick_byte(), 1'($urandom));
          repeat ($urandom_range(0, 3)) pop_random();
        end
        default: run_mixed($urandom_range(8, 40));
      endcase
      first = 1'b0;
      if ($urandom_range(0, 7) == 0) wait_for_replies();
    end

    wait_for_replies();
    repeat (10) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: sortable_byte_deque.f
design/sbd_pkg.sv
design/sbd_cmp.sv
design/sbd_ctrl.sv
design/sortable_byte_deque.sv
dv/testbench.sv
